/* sv/xorshift64star_byte_generator_macros.svh */
// assertion macros shared by the xorshift64* byte generator rtl
`ifndef XORSHIFT64STAR_BYTE_GENERATOR_MACROS_SVH
`define XORSHIFT64STAR_BYTE_GENERATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define XS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define XS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/xs64_pkg.sv */
// types, constants and helper functions of the xorshift64* byte generator
package xs64_pkg;

   localparam int WORD_W    = 64;
   localparam int LEN_W     = 10;
   localparam int BYTES_W   = 4;
   localparam int SEED_NBYTES_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int HALF_W    = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SEED_VALUE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_LENGTH = 2'd1;

   localparam logic [WORD_W-1:0] FALLBACK_SEED = 64'hDEAD_BEEF_DEAD_BEEF;
   localparam logic [WORD_W-1:0] SCRAMBLE_MULT = 64'h2545_F491_4F6C_DD1D;
   localparam logic [WORD_W-1:0] ONE_SEED      = 64'h1;
   localparam logic [7:0]        PAD_BYTE      = 8'hA5;
   localparam logic [BYTES_W-1:0] WORD_BYTES   = 4'd8;

   localparam int SHIFT_A = 12;
   localparam int SHIFT_B = 25;
   localparam int SHIFT_C = 27;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_MUL,
      ST_HOLD
   } gen_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

   // seed from the two registers, lengths above eight act as eight
   function automatic logic [WORD_W-1:0] derive_seed(input logic [WORD_W-1:0] value,
                                                     input logic [SEED_NBYTES_W-1:0] len);
      logic [WORD_W-1:0]        s;
      logic [SEED_NBYTES_W-1:0] n;
      n = (len > SEED_NBYTES_W'(8)) ? SEED_NBYTES_W'(8) : len;
      s = FALLBACK_SEED;
      if (n != '0) begin
         for (int i = 0; i < 8; i++) begin
            s[8*i +: 8] = (SEED_NBYTES_W'(i) < n) ? value[8*i +: 8] : PAD_BYTE;
         end
      end
      if (s == '0) begin
         s = ONE_SEED;
      end
      return s;
   endfunction

   function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] v;
      v = x ^ (x >> SHIFT_A);
      v = v ^ (v << SHIFT_B);
      v = v ^ (v >> SHIFT_C);
      return v;
   endfunction

   // keeps the low take bytes
   function automatic logic [WORD_W-1:0] byte_mask(input logic [BYTES_W-1:0] take);
      logic [WORD_W-1:0] m;
      for (int i = 0; i < 8; i++) begin
         m[8*i +: 8] = (BYTES_W'(i) < take) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

endpackage

/* sv/xs64_if.sv */
// valid/ready channel interfaces of the xorshift64* byte generator

interface xs64_req_if;
   logic                         valid;
   logic                         ready;
   logic [xs64_pkg::LEN_W-1:0]   request_length;

   modport source (output valid, output request_length, input ready);
   modport sink   (input valid, input request_length, output ready);
endinterface

interface xs64_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [xs64_pkg::WORD_W-1:0]  random_word;
   logic [xs64_pkg::BYTES_W-1:0] valid_bytes;
   logic                         last_word;

   modport source (output valid, output random_word, output valid_bytes,
                   output last_word, input ready);
   modport sink   (input valid, input random_word, input valid_bytes,
                   input last_word, output ready);
endinterface

interface xs64_csr_if;
   logic                           valid;
   logic                           ready;
   logic [xs64_pkg::CSR_IDX_W-1:0] index;
   logic [xs64_pkg::WORD_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/xs64_mul.sv */
// iterative low-half 64x64 scramble multiply on one shared 32x32 multiplier
module xs64_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [xs64_pkg::WORD_W-1:0]     operand,
   output xs64_pkg::mul_status_type        status,
   output logic [xs64_pkg::WORD_W-1:0]     product
);
   import xs64_pkg::*;

   logic [WORD_W-1:0] x_ff;
   logic [1:0]        step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [WORD_W-1:0] prod_ff;
   logic [WORD_W-1:0] acc_ff;

   logic [HALF_W-1:0] mul_a;
   logic [HALF_W-1:0] mul_b;
   logic [WORD_W-1:0] mul_out;

   // step 0: lo*lo, step 1: hi*lo, step 2: lo*hi; only low half of cross terms matters
   always_comb begin
      case (step_ff)
         2'd1: begin
            mul_a = x_ff[WORD_W-1:HALF_W];
            mul_b = SCRAMBLE_MULT[HALF_W-1:0];
         end
         2'd2: begin
            mul_a = x_ff[HALF_W-1:0];
            mul_b = SCRAMBLE_MULT[WORD_W-1:HALF_W];
         end
         default: begin
            mul_a = x_ff[HALF_W-1:0];
            mul_b = SCRAMBLE_MULT[HALF_W-1:0];
         end
      endcase
      mul_out = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 2'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // product registered, accumulated one step behind
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= operand;
      end
      if (busy_ff) begin
         prod_ff <= mul_out;
         case (step_ff)
            2'd1:    acc_ff <= prod_ff;
            2'd2,
            2'd3:    acc_ff <= acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
            default: acc_ff <= acc_ff;
         endcase
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

/* sv/xorshift64star_byte_generator.sv */
// top level of the xorshift64* byte generator
// usage:
//  - csr_ch writes seed_value (index 0) or seed_length (index 1); every known
//    write reseeds the generator, other indexes are dropped; always ready
//  - req_ch takes one transaction naming a byte count (0..512, larger values
//    saturate to MAX_REQUEST_BYTES, zero gives no output)
//  - rsp_ch returns ceil(count/8) words, byte 0 in the low bits, the final
//    word partial with its upper bytes zero, last_word set on the final word
// timing:
//  - each word takes one xorshift step (ST_SHIFT), then a pass through the
//    shared 32x32 multiplier (ST_MUL) that builds the low 64 bits of the scramble
//  - req_ch is ready only while no request is in progress; it reopens as
//    the last word enters the output register, so the next request can be
//    taken while that word still waits
// reset: synchronous, clears the channels and seeds 0xDEADBEEFDEADBEEF
// stall: a stalled rsp_ch holds the finished word in the multiplier and
//    freezes the sequencer until the output register frees up
`include "xorshift64star_byte_generator_macros.svh"

module xorshift64star_byte_generator #(
   parameter int MAX_REQUEST_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   xs64_req_if.sink    req_ch,
   xs64_rsp_if.source  rsp_ch,
   xs64_csr_if.sink    csr_ch
);
   import xs64_pkg::*;

   // sequencer
   gen_state_type state_ff, state_in;

   // seed registers and generator state
   logic [WORD_W-1:0]        seed_value_ff;
   logic [SEED_NBYTES_W-1:0] seed_nbytes_ff;
   logic [WORD_W-1:0]        gen_state_ff;
   logic [LEN_W-1:0]         remaining_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [WORD_W-1:0]     rsp_word_ff;
   logic [BYTES_W-1:0]    rsp_bytes_ff;
   logic                  rsp_last_ff;

   logic [LEN_W-1:0]         req_len_sat;
   logic                     req_fire;
   logic                     csr_fire;
   logic                     csr_hit;
   logic [WORD_W-1:0]        seed_value_in;
   logic [SEED_NBYTES_W-1:0] seed_nbytes_in;
   logic [WORD_W-1:0]        shifted;
   logic                     slot_free;
   logic                     result_ready;
   logic                     emit;
   logic                     is_last;
   logic [BYTES_W-1:0]       take;
   logic                     mul_start;
   mul_status_type           mul_stat;
   logic [WORD_W-1:0]        mul_product;

   // shared multiplier unit
   xs64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .operand (shifted),
      .status  (mul_stat),
      .product (mul_product)
   );

   // handshake and datapath helpers
   always_comb begin
      req_fire     = req_ch.valid && req_ch.ready;
      csr_fire     = csr_ch.valid && csr_ch.ready;
      csr_hit      = csr_fire && (csr_ch.index inside {CSR_SEED_VALUE, CSR_SEED_LENGTH});
      req_len_sat  = (req_ch.request_length > LEN_W'(MAX_REQUEST_BYTES)) ?
                     LEN_W'(MAX_REQUEST_BYTES) : req_ch.request_length;
      seed_value_in = (csr_fire && csr_ch.index == CSR_SEED_VALUE) ?
                      csr_ch.data : seed_value_ff;
      seed_nbytes_in = (csr_fire && csr_ch.index == CSR_SEED_LENGTH) ?
                       csr_ch.data[SEED_NBYTES_W-1:0] : seed_nbytes_ff;
      shifted      = xorshift(gen_state_ff);
      slot_free    = !rsp_valid_ff || rsp_ch.ready;
      result_ready = (state_ff == ST_MUL && mul_stat.done) || state_ff == ST_HOLD;
      emit         = result_ready && slot_free;
      take         = (remaining_ff >= LEN_W'(WORD_BYTES)) ?
                     WORD_BYTES : remaining_ff[BYTES_W-1:0];
      is_last      = remaining_ff <= LEN_W'(WORD_BYTES);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_len_sat != '0) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: state_in = ST_MUL;
         ST_MUL: begin
            if (mul_stat.done) begin
               if (slot_free) begin
                  state_in = is_last ? ST_IDLE : ST_SHIFT;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               state_in = is_last ? ST_IDLE : ST_SHIFT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      mul_start    = (state_ff == ST_SHIFT);
      csr_ch.ready = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         seed_value_ff  <= '0;
         seed_nbytes_ff <= '0;
         gen_state_ff   <= FALLBACK_SEED;
         remaining_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         // reseed on any register write, otherwise advance once per word
         seed_value_ff  <= seed_value_in;
         seed_nbytes_ff <= seed_nbytes_in;
         if (csr_hit) begin
            gen_state_ff <= derive_seed(seed_value_in, seed_nbytes_in);
         end else if (mul_start) begin
            gen_state_ff <= shifted;
         end

         if (req_fire) begin
            remaining_ff <= req_len_sat;
         end else if (emit) begin
            remaining_ff <= remaining_ff - LEN_W'(take);
         end

         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // output payload, no reset needed
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_word_ff  <= mul_product & byte_mask(take);
         rsp_bytes_ff <= take;
         rsp_last_ff  <= is_last;
      end
   end

   always_comb begin
      rsp_ch.valid       = rsp_valid_ff;
      rsp_ch.random_word = rsp_word_ff;
      rsp_ch.valid_bytes = rsp_bytes_ff;
      rsp_ch.last_word   = rsp_last_ff;
   end

   // checks
   `XS_ASSERT_NOW(a_state_nonzero, clock, reset, 1'b1, gen_state_ff != '0, "generator state is zero")
   `XS_ASSERT_NEXT(a_last_drains, clock, reset, emit && is_last, remaining_ff == '0, "bytes left after last word")
   `XS_ASSERT_NOW(a_bytes_range, clock, reset, rsp_valid_ff, rsp_bytes_ff != '0 && rsp_bytes_ff <= WORD_BYTES, "valid_bytes out of range")
   `XS_ASSERT_NOW(a_done_in_mul, clock, reset, mul_stat.done, state_ff == ST_MUL, "multiplier finished outside its state")
   `XS_ASSERT_NOW(a_idle_drained, clock, reset, state_ff == ST_IDLE, !mul_stat.busy, "multiplier busy while idle")

endmodule

/* tb/testbench.sv */
// testbench of the xorshift64* byte generator: predicts every word of every request and checks it

package xs64_tb_pkg;
   import xs64_pkg::*;

   // indexes with no register behind them, writes there must not reseed
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int MAX_PRINTED = 30;

   typedef struct {
      logic [WORD_W-1:0]  word;
      logic [BYTES_W-1:0] nbytes;
      logic               last;
   } stream_word_type;

   class byte_stream_scoreboard;
      logic [WORD_W-1:0]        seed_word;
      logic [SEED_NBYTES_W-1:0] seed_nbytes;
      logic [WORD_W-1:0]        gen_state;
      int                       max_bytes;
      stream_word_type          pending_words[$];
      int                       mismatches;
      int                       words_checked;

      function new(int max_req_bytes);
         max_bytes     = max_req_bytes;
         seed_word     = '0;
         seed_nbytes   = '0;
         mismatches    = 0;
         words_checked = 0;
         reseed();
      endfunction

      function void reseed();
         logic [SEED_NBYTES_W-1:0] n;
         logic [WORD_W-1:0]        keep;
         logic [WORD_W-1:0]        s;
         n = (seed_nbytes > 4'd8) ? 4'd8 : seed_nbytes;
         if (n == 0) begin
            s = FALLBACK_SEED;
         end else if (n == 4'd8) begin
            s = seed_word;
         end else begin
            keep = (64'd1 << (8 * n)) - 64'd1;
            s = (seed_word & keep) | ({8{PAD_BYTE}} & ~keep);
         end
         gen_state = (s == '0) ? ONE_SEED : s;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
         case (idx)
            CSR_SEED_VALUE: begin
               seed_word = data;
               reseed();
            end
            CSR_SEED_LENGTH: begin
               seed_nbytes = data[SEED_NBYTES_W-1:0];
               reseed();
            end
            default: begin
               // no register here, state untouched
            end
         endcase
      endfunction

      // accepted request: queue one word per eight bytes, rounded up
      function void note_request(logic [LEN_W-1:0] len);
         int unsigned       left;
         int unsigned       take;
         logic [WORD_W-1:0] v;
         stream_word_type   w;
         left = (len > max_bytes) ? max_bytes : len;
         while (left > 0) begin
            v = gen_state;
            v = v ^ (v >> SHIFT_A);
            v = v ^ (v << SHIFT_B);
            v = v ^ (v >> SHIFT_C);
            gen_state = v;
            w.word = v * SCRAMBLE_MULT;
            take = (left >= 8) ? 8 : left;
            if (take < 8) begin
               w.word = w.word & ((64'd1 << (8 * take)) - 64'd1);
            end
            left = left - take;
            w.nbytes = take[BYTES_W-1:0];
            w.last = (left == 0);
            pending_words.push_back(w);
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_PRINTED) begin
            $display("mismatch at word %0d: %s", words_checked, what);
         end
      endtask

      task check_word(logic [WORD_W-1:0] word, logic [BYTES_W-1:0] nbytes, logic last);
         stream_word_type want;
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h bytes %0d last %b",
                                      word, nbytes, last));
            return;
         end
         want = pending_words.pop_front();
         words_checked++;
         if (word !== want.word) begin
            report_mismatch($sformatf("random_word %h, expected %h", word, want.word));
         end
         if (nbytes !== want.nbytes) begin
            report_mismatch($sformatf("valid_bytes %0d, expected %0d", nbytes, want.nbytes));
         end
         if (last !== want.last) begin
            report_mismatch($sformatf("last_word %b, expected %b", last, want.last));
         end
      endtask
   endclass
endpackage

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import xs64_pkg::*;
   import xs64_tb_pkg::*;

   localparam int CLK_PERIOD    = 20;
   localparam int RESET_CYCLES  = 6;
   localparam int MAX_REQ       = 512;
   localparam int RANDOM_ITEMS  = 314;
   localparam int MAX_GAP       = 6;
   // a word passes the xorshift and multiply steps before output, leave margin
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLD     = 300;

   logic clock = 1'b0;
   logic reset;

   xs64_req_if req_ch ();
   xs64_rsp_if rsp_ch ();
   xs64_csr_if csr_ch ();

   xorshift64star_byte_generator #(
      .MAX_REQUEST_BYTES(MAX_REQ)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   byte_stream_scoreboard sb;

   // shared pacing knobs, set by the stimulus process; rsp_side clears rsp_hold
   int idle_max = MAX_GAP;
   int rsp_hold = 0;

   // run statistics for the summary
   int requests_sent      = 0;
   int saturated_requests = 0;
   int empty_requests     = 0;
   int csr_writes         = 0;
   int spare_writes       = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // monitors: both read pre-edge values, so ordering within the step does not matter
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         sb.note_request(req_ch.request_length);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_word(rsp_ch.random_word, rsp_ch.valid_bytes, rsp_ch.last_word);
      end
   end

   // result side: random back-pressure per transaction, plus the long hold-off on request
   initial begin : rsp_side
      int gap;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold > 0) begin
            // long stall so the block fills and closes its input
            rsp_ch.ready <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end
         gap = $urandom_range(0, idle_max);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         // leave early when a hold-off is requested; ready was high, so nothing is lost
         do @(posedge clock); while (!rsp_ch.valid && rsp_hold == 0);
      end
   end

   // offer one request transaction after a random gap, return once it is taken
   task automatic send_request(input logic [LEN_W-1:0] len);
      int gap;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.request_length <= len;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
      if (len > MAX_REQ) begin
         saturated_requests++;
      end
      if (len == 0) begin
         empty_requests++;
      end
   endtask

   // sender pauses until every queued word has been seen
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      // wait so the monitor has logged the last accepted request
      @(posedge clock);
      while (sb.pending_words.size() != 0) @(posedge clock);
   endtask

   // block idle: drained, and long enough for an empty request to be finished too
   task automatic settle();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_register(idx, data);
      csr_writes++;
      if (idx inside {CSR_SPARE_A, CSR_SPARE_B}) begin
         spare_writes++;
      end
      // short idle gap before the next write
      csr_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clock);
   endtask

   // mostly short requests, a few long and saturating ones, some empty
   function automatic logic [LEN_W-1:0] random_length();
      logic [LEN_W-1:0] len;
      case ($urandom_range(0, 9)) inside
         0:       len = '0;
         [1:2]:   len = LEN_W'($urandom_range(1, 16));
         [3:6]:   len = LEN_W'($urandom_range(17, 64));
         7:       len = LEN_W'($urandom_range(65, 511));
         8:       len = LEN_W'($urandom_range(512, 1023));
         default: len = LEN_W'($urandom_range(0, 1023));
      endcase
      return len;
   endfunction

   function automatic logic [WORD_W-1:0] random_seed_word();
      logic [WORD_W-1:0] w;
      case ($urandom_range(0, 7))
         0:       w = '0;
         1:       w = '1;
         default: w = {$urandom(), $urandom()};
      endcase
      return w;
   endfunction

   // random upper bits ride along, only the low nibble is the length
   function automatic logic [WORD_W-1:0] random_seed_length();
      logic [WORD_W-1:0] w;
      w = {$urandom(), $urandom()};
      w[SEED_NBYTES_W-1:0] = SEED_NBYTES_W'($urandom_range(0, 15));
      return w;
   endfunction

   initial begin : stimulus
      int chunk_len;
      int chunk_no;
      int random_sent;
      int pick;

      sb = new(MAX_REQ);
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.request_length <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_SEED_VALUE;
      csr_ch.data  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: reset seed, empty, single byte, exact word, one over, saturation
      send_request(10'd0);
      send_request(10'd1);
      send_request(10'd8);
      send_request(10'd9);
      send_request(10'd1023);
      send_request(10'd512);

      // one seed byte kept, seven padded
      settle();
      write_csr(CSR_SEED_LENGTH, 64'd1);
      write_csr(CSR_SEED_VALUE, '1);
      send_request(10'd7);
      send_request(10'd15);

      // seven seed bytes kept
      settle();
      write_csr(CSR_SEED_LENGTH, 64'd7);
      send_request(10'd16);
      send_request(10'd3);

      // full zero seed collapses to one
      settle();
      write_csr(CSR_SEED_VALUE, '0);
      write_csr(CSR_SEED_LENGTH, 64'd8);
      send_request(10'd513);
      send_request(10'd24);

      // length fifteen behaves as eight
      settle();
      write_csr(CSR_SEED_LENGTH, 64'd15);
      send_request(10'd40);

      // writes to unused indexes must leave the stream running on
      settle();
      write_csr(CSR_SPARE_A, {$urandom(), $urandom()});
      write_csr(CSR_SPARE_B, '1);
      send_request(10'd17);

      // length zero goes back to the fallback seed
      settle();
      write_csr(CSR_SEED_LENGTH, '0);
      send_request(10'd5);

      // random seed, length four with junk above the nibble
      settle();
      write_csr(CSR_SEED_VALUE, {$urandom(), $urandom()});
      write_csr(CSR_SEED_LENGTH, {$urandom(), 28'hFFFFFF0, 4'd4});
      send_request(10'd200);

      // random part in chunks, each with its own seed setting and pacing
      random_sent = 0;
      chunk_no = 0;
      while (random_sent < RANDOM_ITEMS) begin
         settle();
         repeat ($urandom_range(1, 3)) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               write_csr(CSR_SEED_VALUE, random_seed_word());
            end else if (pick < 9) begin
               write_csr(CSR_SEED_LENGTH, random_seed_length());
            end else begin
               write_csr(($urandom_range(0, 1) != 0) ? CSR_SPARE_A : CSR_SPARE_B,
                         {$urandom(), $urandom()});
            end
         end
         idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
         if (chunk_no == 1) begin
            // receiver stalls while the sender keeps offering back to back
            idle_max = 0;
            rsp_hold = LONG_HOLD;
         end
         chunk_len = $urandom_range(15, 35);
         repeat (chunk_len) begin
            send_request(random_length());
            random_sent++;
            if ($urandom_range(0, 19) == 0) begin
               wait_for_results();
            end
         end
         chunk_no++;
      end

      settle();
      $display("covered %0d requests (%0d saturated, %0d empty), %0d words checked",
               requests_sent, saturated_requests, empty_requests, sb.words_checked);
      $display("seed changes: %0d register writes, %0d of them to unused indexes",
               csr_writes, spare_writes);
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end

   // hang guard, several times the slowest correct run
   initial begin : watchdog
      #40ms;
      $display("timeout with %0d words outstanding", sb.pending_words.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
